// File: rtl/latency_window_average_defines.svh
// Assertion helpers used by latency_window_average.sv.
// Every helper samples on the rising edge of clk and is off while rst is high.
`ifndef LATENCY_WINDOW_AVERAGE_DEFINES_SVH
`define LATENCY_WINDOW_AVERAGE_DEFINES_SVH

// The expression holds at every clock edge.
`define LWA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// The consequent holds at the edge where the antecedent holds.
`define LWA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds at the edge after the one where the antecedent holds.
`define LWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lwa_pkg.sv
`default_nettype none

package lwa_pkg;

  // Reset value of the stale limit, in ms
  localparam logic [31:0] STALE_RESET = 32'd30000;

  // Average code reported when no fresh contact or no query is known (-1)
  localparam logic signed [16:0] AVG_UNAVAILABLE = -17'sd1;

  // Width of one latency sample
  localparam int SAMPLE_W = 16;

  // One input item
  typedef struct packed {
    logic [31:0]         now_ms;
    logic                clear;
    logic                contact_seen;
    logic                query_sent;
    logic                sample_valid;
    logic [SAMPLE_W-1:0] sample_ms;
  } req_item_t;

  // One result item
  typedef struct packed {
    logic signed [16:0] average_ms;
    logic [4:0]         samples_held;
  } rsp_item_t;

  // Item sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DIV,
    ST_FIN
  } lwa_state_t;

endpackage

`default_nettype wire

// File: rtl/lwa_ram.sv
`default_nettype none

module lwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/latency_window_average.sv
// Latency window average.
// req channel (req_valid / req_stall / req): one item per accept carrying the
// current ms tick, clear / contact / query marks and an optional latency sample.
// rsp channel (rsp_valid / rsp_stall / rsp): exactly one result per item with
// the mean of the last DEPTH samples (or -1 when no fresh contact or no query is known)
// and the number of samples held.
// cfg channel (cfg_valid / cfg_ready / cfg_data): writes the stale limit in ms;
// cfg_ready is always high. Write it only while no item is in flight.
// Steps: the accept edge reads the oldest sample, then ST_PUSH updates the
// ring and sum, ST_DIV runs the bit-serial divider and ST_FIN loads the
// result register once the output register is free. req_stall is high from
// the accept until the result loads, so the block takes a new item only
// after it is through with the last one.
// A new item is accepted while the previous result still waits in the output
// register; if the receiver stalls, the next result waits in the divider.
// Reset (rst, synchronous) empties the window, forgets contact and query and
// sets the stale limit to 30000 ms. The sample memory needs no clearing:
// an entry is read only once it has been written.
`default_nettype none

`include "latency_window_average_defines.svh"

module latency_window_average #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire lwa_pkg::req_item_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output lwa_pkg::rsp_item_t     rsp,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [31:0]       cfg_data
);

  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = lwa_pkg::SAMPLE_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  lwa_pkg::lwa_state_t state, state_next;
  lwa_pkg::req_item_t  item;

  logic [31:0]       stale_limit;
  logic [IDX_W-1:0]  write_index;
  logic [CNT_W-1:0]  valid_count;
  logic [SUM_W-1:0]  window_sum;
  logic [31:0]       last_contact_time;
  logic              contact_known;
  logic              query_known;
  logic              unavail;

  logic [CNT_W-1:0]     div_rem;
  logic [SUM_W-1:0]     div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                         ram_we;
  logic [lwa_pkg::SAMPLE_W-1:0] ram_rdata;

  logic req_take;
  logic window_full;
  logic div_done;
  logic rsp_load;
  logic [SUM_W-1:0] sum_upd;
  logic [CNT_W-1:0] count_upd;
  logic [31:0]      contact_age;
  logic [CNT_W:0]   div_trial;
  logic             div_bit;
  logic [31:0]      count_wide;

  assign cfg_ready = 1'b1;

  // Sample ring
  lwa_ram #(
    .WIDTH (lwa_pkg::SAMPLE_W),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (item.sample_ms),
    .raddr (write_index),
    .rdata (ram_rdata)
  );

  // Ring and sum update for the pending sample
  always_comb begin
    window_full = (valid_count == CNT_W'(DEPTH));
    sum_upd     = window_sum;
    count_upd   = valid_count;
    if (item.sample_valid) begin
      if (window_full) begin
        sum_upd = window_sum + SUM_W'(item.sample_ms) - SUM_W'(ram_rdata);
      end else begin
        sum_upd   = window_sum + SUM_W'(item.sample_ms);
        count_upd = valid_count + CNT_W'(1);
      end
    end
    contact_age = item.now_ms - last_contact_time;
  end

  // Divider step: shift in one dividend bit, subtract when it fits
  always_comb begin
    div_trial = {div_rem, div_quo[SUM_W-1]};
    div_bit   = (div_trial >= {1'b0, valid_count});
    div_done  = (div_cnt == DIV_CNT_W'(SUM_W - 1));
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    req_take   = 1'b0;
    ram_we     = 1'b0;
    rsp_load   = 1'b0;
    unique case (state)
      lwa_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        req_take  = req_valid;
        if (req_valid) begin
          state_next = lwa_pkg::ST_PUSH;
        end
      end
      lwa_pkg::ST_PUSH: begin
        ram_we     = item.sample_valid;
        state_next = lwa_pkg::ST_DIV;
      end
      lwa_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lwa_pkg::ST_FIN;
        end
      end
      lwa_pkg::ST_FIN: begin
        rsp_load = !rsp_valid || !rsp_stall;
        if (rsp_load) begin
          state_next = lwa_pkg::ST_IDLE;
        end
      end
      default: state_next = lwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stale limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= lwa_pkg::STALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stale_limit <= cfg_data;
    end
  end

  // Window state: clear first, then marks, then the sample
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index       <= '0;
      valid_count       <= '0;
      window_sum        <= '0;
      last_contact_time <= '0;
      contact_known     <= 1'b0;
      query_known       <= 1'b0;
    end else if (req_take) begin
      if (req.clear) begin
        write_index <= '0;
        valid_count <= '0;
        window_sum  <= '0;
      end
      if (req.contact_seen) begin
        last_contact_time <= req.now_ms;
      end
      contact_known <= req.contact_seen || (contact_known && !req.clear);
      query_known   <= req.query_sent || (query_known && !req.clear);
    end else if (state == lwa_pkg::ST_PUSH) begin
      valid_count <= count_upd;
      window_sum  <= sum_upd;
      if (item.sample_valid) begin
        if (write_index == IDX_W'(DEPTH - 1)) begin
          write_index <= '0;
        end else begin
          write_index <= write_index + IDX_W'(1);
        end
      end
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (req_take) begin
      item <= req;
    end
  end

  // Freshness check and divider
  always_ff @(posedge clk) begin
    if (state == lwa_pkg::ST_PUSH) begin
      unavail <= !contact_known || !query_known || (contact_age > stale_limit);
      div_quo <= sum_upd;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (state == lwa_pkg::ST_DIV) begin
      div_quo <= {div_quo[SUM_W-2:0], div_bit};
      div_rem <= div_bit ? CNT_W'(div_trial - {1'b0, valid_count})
                         : CNT_W'(div_trial);
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Output register
  assign count_wide = 32'(valid_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.samples_held <= count_wide[4:0];
      if (unavail) begin
        rsp.average_ms <= lwa_pkg::AVG_UNAVAILABLE;
      end else if (valid_count == '0) begin
        rsp.average_ms <= '0;
      end else begin
        rsp.average_ms <= {1'b0, div_quo[lwa_pkg::SAMPLE_W-1:0]};
      end
    end
  end

  // Checks
  `LWA_ASSERT_ALWAYS(a_count_bound, valid_count <= CNT_W'(DEPTH),
    "valid count exceeds window depth")
  `LWA_ASSERT_ALWAYS(a_index_bound, write_index <= IDX_W'(DEPTH - 1),
    "write index outside the ring")
  `LWA_ASSERT_NEXT(a_clear_empties, req_take && req.clear,
    valid_count == '0 && window_sum == '0 && write_index == '0,
    "clear did not empty the window")
  `LWA_ASSERT_SAME(a_empty_sum, state == lwa_pkg::ST_IDLE && valid_count == '0,
    window_sum == '0, "empty window with nonzero sum")
  `LWA_ASSERT_NEXT(a_full_stays, state == lwa_pkg::ST_PUSH && window_full,
    valid_count == CNT_W'(DEPTH), "full window lost a sample")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;

  localparam int RING = 16;
  localparam int DRAIN_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 370;
  localparam int NUM_PHASES = 5;
  localparam logic [31:0] LIMIT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] LIMIT_ZERO = 32'd0;
  localparam logic [15:0] SAMPLE_MAX = 16'hFFFF;

  // One row of the directed table; want is used only when pinned is set
  typedef struct {
    lwa_pkg::req_item_t item;
    bit                 pinned;
    lwa_pkg::rsp_item_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  lwa_pkg::req_item_t req;
  logic               rsp_valid;
  logic               rsp_stall;
  lwa_pkg::rsp_item_t rsp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;

  // Window tracker state
  logic [15:0] ring_copy [RING];
  logic [3:0]  slot_next;
  logic [4:0]  held_cnt;
  logic [19:0] sum_acc;
  logic [31:0] contact_stamp;
  bit          contact_known;
  bit          query_known;
  logic [31:0] stale_limit;

  lwa_pkg::rsp_item_t mean_expected_q [$];
  stim_row_t          stim_table [$];
  bit                 cur_pinned;
  lwa_pkg::rsp_item_t cur_want;
  bit                 quiet;
  int                 hold_left;
  int                 idle_cycles;
  int                 errors;
  logic [31:0]        clock_now;

  latency_window_average i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Advance the window tracker by one item and return the result it causes
  function automatic lwa_pkg::rsp_item_t window_mean_step(lwa_pkg::req_item_t it);
    lwa_pkg::rsp_item_t res;
    logic [31:0]        age;
    if (it.clear) begin
      slot_next = '0;
      held_cnt = '0;
      sum_acc = '0;
      contact_known = 1'b0;
      query_known = 1'b0;
    end
    if (it.contact_seen) begin
      contact_stamp = it.now_ms;
      contact_known = 1'b1;
    end
    if (it.query_sent) begin
      query_known = 1'b1;
    end
    if (it.sample_valid) begin
      // drop the oldest sample once the window is full
      if (held_cnt >= RING) begin
        sum_acc = sum_acc - ring_copy[slot_next];
      end else begin
        held_cnt = held_cnt + 5'd1;
      end
      ring_copy[slot_next] = it.sample_ms;
      sum_acc = sum_acc + it.sample_ms;
      slot_next = slot_next + 4'd1;
    end
    age = it.now_ms - contact_stamp;
    res.samples_held = held_cnt;
    if (!contact_known || !query_known || age > stale_limit) begin
      res.average_ms = lwa_pkg::AVG_UNAVAILABLE;
    end else if (held_cnt == 0) begin
      res.average_ms = '0;
    end else begin
      res.average_ms = 17'(sum_acc / held_cnt);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
    errors++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  task automatic add_row(logic [31:0] now, bit clr, bit con, bit qry, bit sv,
                         logic [15:0] smp, bit pinned, logic signed [16:0] avg,
                         logic [4:0] held);
    stim_row_t row;
    row.item.now_ms = now;
    row.item.clear = clr;
    row.item.contact_seen = con;
    row.item.query_sent = qry;
    row.item.sample_valid = sv;
    row.item.sample_ms = smp;
    row.pinned = pinned;
    row.want.average_ms = avg;
    row.want.samples_held = held;
    stim_table.push_back(row);
  endtask

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_item(lwa_pkg::req_item_t it, bit pinned, lwa_pkg::rsp_item_t want);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = it;
    cur_pinned = pinned;
    cur_want = want;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Wait until every result is in, then let the block settle
  task automatic drain();
    req_valid = 1'b0;
    while (mean_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Build a well-formed item on a running clock, with some noise
  function automatic lwa_pkg::req_item_t random_item();
    lwa_pkg::req_item_t it;
    int                 d;
    if ($urandom_range(0, 99) < 5) begin
      it.now_ms = $urandom;
      it.clear = $urandom_range(0, 1);
      it.contact_seen = $urandom_range(0, 1);
      it.query_sent = $urandom_range(0, 1);
      it.sample_valid = $urandom_range(0, 1);
      it.sample_ms = $urandom;
      return it;
    end
    d = $urandom_range(0, 99);
    if (d < 70) begin
      clock_now = clock_now + $urandom_range(0, 20);
    end else if (d < 90) begin
      clock_now = clock_now + $urandom_range(0, 400);
    end else if (d < 97) begin
      clock_now = clock_now + $urandom_range(0, 40000);
    end else begin
      clock_now = clock_now + $urandom;
    end
    it.now_ms = clock_now;
    it.clear = $urandom_range(0, 99) < 2;
    it.contact_seen = $urandom_range(0, 99) < 40;
    it.query_sent = $urandom_range(0, 99) < 30;
    it.sample_valid = $urandom_range(0, 99) < 55;
    d = $urandom_range(0, 99);
    if (d < 10) begin
      it.sample_ms = SAMPLE_MAX;
    end else if (d < 15) begin
      it.sample_ms = '0;
    end else begin
      it.sample_ms = $urandom;
    end
    return it;
  endfunction

  // Receiver stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_stall = 1'b1;
      hold_left--;
    end else begin
      rsp_stall = 1'b0;
      if (!quiet && $urandom_range(0, 99) < 25) begin
        hold_left = pick_gap();
      end
    end
  end

  // Track accepted items, check results, watch for a hang
  always @(posedge clk) begin
    lwa_pkg::rsp_item_t pred;
    lwa_pkg::rsp_item_t want;
    bit                 moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        stale_limit = cfg_data;
        moved = 1'b1;
      end
      if (req_valid && !req_stall) begin
        pred = window_mean_step(req);
        mean_expected_q.push_back(cur_pinned ? cur_want : pred);
        moved = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        if (mean_expected_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(rsp), '0);
        end else begin
          want = mean_expected_q.pop_front();
          if (rsp.average_ms !== want.average_ms) begin
            report_mismatch("average_ms", 32'(rsp.average_ms), 32'(want.average_ms));
          end
          if (rsp.samples_held !== want.samples_held) begin
            report_mismatch("samples_held", 32'(rsp.samples_held),
                            32'(want.samples_held));
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0]        limits [NUM_PHASES];
    lwa_pkg::rsp_item_t no_want;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_pinned = 1'b0;
    cur_want = '0;
    no_want = '0;
    quiet = 1'b0;
    hold_left = 0;
    idle_cycles = 0;
    errors = 0;
    clock_now = '0;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    slot_next = '0;
    held_cnt = '0;
    sum_acc = '0;
    contact_stamp = '0;
    contact_known = 1'b0;
    query_known = 1'b0;
    stale_limit = lwa_pkg::STALE_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: after reset, contact and query alone, extremes of samples
    add_row(32'd0, 0, 0, 0, 0, '0, 1, lwa_pkg::AVG_UNAVAILABLE, 5'd0);
    add_row(32'd100, 0, 1, 0, 0, '0, 1, lwa_pkg::AVG_UNAVAILABLE, 5'd0);
    add_row(32'd100, 0, 0, 1, 0, '0, 1, 17'sd0, 5'd0);
    add_row(32'd200, 0, 0, 0, 1, SAMPLE_MAX, 1, 17'sd65535, 5'd1);
    add_row(32'd300, 0, 0, 0, 1, '0, 1, 17'sd32767, 5'd2);
    // fill the window, then overwrite the oldest sample
    for (int i = 0; i < 14; i++) begin
      add_row(32'd400 + i, 0, 0, 0, 1, SAMPLE_MAX, 0, '0, '0);
    end
    add_row(32'd500, 0, 0, 0, 1, 16'd7, 0, '0, '0);
    // stale boundary at the reset limit
    add_row(32'd30100, 0, 0, 0, 0, '0, 0, '0, '0);
    add_row(32'd30101, 0, 0, 0, 0, '0, 1, lwa_pkg::AVG_UNAVAILABLE, 5'd16);
    // contact age across the time wrap
    add_row(32'hFFFF_FFF0, 0, 1, 0, 0, '0, 0, '0, '0);
    add_row(32'h0000_0010, 0, 0, 0, 0, '0, 0, '0, '0);
    // clear alone, clear ahead of the other marks, all bits set
    add_row(32'h0000_0020, 1, 0, 0, 0, '0, 1, lwa_pkg::AVG_UNAVAILABLE, 5'd0);
    add_row(32'h0000_0030, 1, 1, 1, 1, 16'd1234, 1, 17'sd1234, 5'd1);
    add_row(32'hFFFF_FFFF, 1, 1, 1, 1, SAMPLE_MAX, 1, 17'sd65535, 5'd1);
    add_row(32'h0000_0040, 1, 1, 0, 0, '0, 1, lwa_pkg::AVG_UNAVAILABLE, 5'd0);

    foreach (stim_table[i]) begin
      send_item(stim_table[i].item, stim_table[i].pinned, stim_table[i].want);
    end
    drain();

    // Random phases, one stale limit each
    limits[0] = LIMIT_ZERO;
    limits[1] = 32'd150;
    limits[2] = LIMIT_MAX;
    limits[3] = lwa_pkg::STALE_RESET;
    limits[4] = $urandom_range(0, 1000);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(limits[p]);
      clock_now = ($urandom_range(0, 1) == 1) ? 32'hFFFF_F000 : $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) begin
          quiet = $urandom_range(0, 3) == 0;
        end
        send_item(random_item(), 1'b0, no_want);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
